// ----- rtl/d96rti_pkg.sv -----
// Shared types, constants and the divide-by-ten helper for the decimal rounding pipeline.
package d96rti_pkg;

    localparam int MaxScale   = 28;
    localparam int ChunkCount = 3;
    localparam int StageCount = MaxScale * ChunkCount;

    // Reciprocal of ten for exact division of a 36-bit dividend below 10 * 2**32.
    localparam logic [35:0] RecipTen = 36'hCCCCCCCCD;
    localparam int          RecipShift = 39;

    typedef enum logic [1:0] {
        CMD_NEGATE   = 2'd0,
        CMD_TRUNCATE = 2'd1,
        CMD_ROUND    = 2'd2,
        CMD_FLOOR    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        neg;
        logic [4:0]  scale;
        logic [4:0]  steps;
        logic [95:0] mag;
        logic [3:0]  rem;
        logic [3:0]  digit;
        logic        nz;
    } word_t;

    typedef struct packed {
        logic [31:0] quo;
        logic [3:0]  rem;
    } qr_t;

    // Divide {rem, chunk} by ten; the dividend is always below 10 * 2**32.
    function automatic qr_t div10_chunk(input logic [35:0] part);
        logic [71:0] prod;
        logic [35:0] back;
        qr_t         res;
        prod     = part * RecipShift'(0) + part * RecipTen;
        res.quo  = prod[RecipShift +: 32];
        back     = {4'd0, res.quo} * 36'd10;
        res.rem  = 4'(part - back);
        return res;
    endfunction

endpackage

// ----- rtl/d96rti_chunk.sv -----
// One pipeline stage that divides one 32-bit chunk of the magnitude by ten.
module d96rti_chunk (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [4:0]          step_idx,
    input  logic [1:0]          chunk_sel,
    input  logic                valid_in,
    input  d96rti_pkg::word_t   word_in,
    output logic                valid_out,
    output d96rti_pkg::word_t   word_out
);

    logic              valid_reg;
    d96rti_pkg::word_t word_reg;
    d96rti_pkg::word_t word_next;
    logic [31:0]       chunk;
    logic [3:0]        rem_in;
    d96rti_pkg::qr_t   qr;
    logic              active;

    always_comb
    begin
        active = step_idx < word_in.steps;
        case (chunk_sel)
            2'd0:    chunk = word_in.mag[95:64];
            2'd1:    chunk = word_in.mag[63:32];
            default: chunk = word_in.mag[31:0];
        endcase
        rem_in = (chunk_sel == 2'd0) ? 4'd0 : word_in.rem;
        qr = d96rti_pkg::div10_chunk({rem_in, chunk});
        word_next = word_in;
        if (active)
        begin
            word_next.rem = qr.rem;
            case (chunk_sel)
                2'd0:    word_next.mag[95:64] = qr.quo;
                2'd1:    word_next.mag[63:32] = qr.quo;
                default:
                begin
                    word_next.mag[31:0] = qr.quo;
                    word_next.digit     = qr.rem;
                    word_next.nz        = word_in.nz | (qr.rem != 4'd0);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

// ----- rtl/d96rti_fix.sv -----
// Final stage: applies the rounding increment and forms the result registers.
module d96rti_fix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  d96rti_pkg::word_t  word_in,
    output logic               valid_out,
    output logic [95:0]        mag_out,
    output logic [4:0]         scale_out,
    output logic               neg_out
);

    logic        valid_reg;
    logic [95:0] mag_reg;
    logic [4:0]  scale_reg;
    logic        neg_reg;
    logic        bump;

    always_comb
    begin
        bump = 1'b0;
        if (word_in.steps != 5'd0)
        begin
            unique case (word_in.cmd)
                d96rti_pkg::CMD_ROUND: bump = word_in.digit >= 4'd5;
                d96rti_pkg::CMD_FLOOR: bump = word_in.neg & word_in.nz;
                default:               bump = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= word_in.mag + {95'd0, bump};
            if (word_in.cmd == d96rti_pkg::CMD_NEGATE)
            begin
                scale_reg <= word_in.scale;
                neg_reg   <= ~word_in.neg;
            end
            else
            begin
                scale_reg <= 5'd0;
                neg_reg   <= word_in.neg;
            end
        end
    end

    assign valid_out = valid_reg;
    assign mag_out   = mag_reg;
    assign scale_out = scale_reg;
    assign neg_out   = neg_reg;

endmodule

// ----- rtl/decimal96_round_to_integer.sv -----
// Top level of the scaled-decimal negate, truncate, round and floor pipeline.
// The pipeline has 84 chunk stages (28 divide-by-ten steps of three chunks) and one
// increment stage that also serves as the output register.
// Throughput is one word per cycle; every stage takes a new word whenever the output
// register is empty or its word is being taken, so a stall freezes the whole pipeline.
// Reset is asynchronous and active low; it clears all valid bits, payload is not reset.
module decimal96_round_to_integer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [63:0] mant_lo,
    input  logic [31:0] mant_hi,
    input  logic [4:0]  scale,
    input  logic        negative,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] res_lo,
    output logic [31:0] res_hi,
    output logic [4:0]  res_scale,
    output logic        res_negative
);

    // The pipeline advances as a unit unless a finished word sits stalled at the output.
    logic               en;
    logic               valid_q [d96rti_pkg::StageCount + 1];
    d96rti_pkg::word_t  word_q  [d96rti_pkg::StageCount + 1];
    d96rti_pkg::word_t  entry;
    logic [95:0]        mag_res;

    assign en       = ~(out_valid & out_stall);
    assign in_stall = ~en;

    // Negate skips all division steps; the others clamp the step count to MaxScale.
    always_comb
    begin
        entry.cmd   = d96rti_pkg::cmd_t'(cmd);
        entry.neg   = negative;
        entry.scale = scale;
        entry.mag   = {mant_hi, mant_lo};
        entry.rem   = 4'd0;
        entry.digit = 4'd0;
        entry.nz    = 1'b0;
        if (entry.cmd == d96rti_pkg::CMD_NEGATE)
        begin
            entry.steps = 5'd0;
        end
        else if (scale > 5'(d96rti_pkg::MaxScale))
        begin
            entry.steps = 5'(d96rti_pkg::MaxScale);
        end
        else
        begin
            entry.steps = scale;
        end
    end

    assign valid_q[0] = in_valid;
    assign word_q[0]  = entry;

    // Each step takes the high, middle and low chunk in turn, passing the remainder down.
    for (genvar g = 0; g < d96rti_pkg::StageCount; g++)
    begin : g_stage
        d96rti_chunk u_chunk (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step_idx  (5'(g / d96rti_pkg::ChunkCount)),
            .chunk_sel (2'(g % d96rti_pkg::ChunkCount)),
            .valid_in  (valid_q[g]),
            .word_in   (word_q[g]),
            .valid_out (valid_q[g + 1]),
            .word_out  (word_q[g + 1])
        );
    end

    d96rti_fix u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (valid_q[d96rti_pkg::StageCount]),
        .word_in   (word_q[d96rti_pkg::StageCount]),
        .valid_out (out_valid),
        .mag_out   (mag_res),
        .scale_out (res_scale),
        .neg_out   (res_negative)
    );

    assign res_lo = mag_res[63:0];
    assign res_hi = mag_res[95:64];

endmodule

// ----- rtl/d96rti_checker.sv -----
// Port-level checks for the decimal rounding pipeline, bound to the top level.
module d96rti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] res_lo,
    input logic [4:0]  res_scale
);

    // A stalled result word holds its low 64 bits and its scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_lo) && $stable(res_scale))
        else $error("stalled result changed");

    // The input side stalls only behind a stalled, valid output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // When the output word is taken or absent the input is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || !out_stall |-> !in_stall)
        else $error("input stalled with free output");

endmodule

bind decimal96_round_to_integer d96rti_checker u_d96rti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_lo    (res_lo),
    .res_scale (res_scale)
);
